>>> hw/rtl/ptc_pkg.sv
// Shared types, codes and helpers for the packed timestamp codec.
// Used by ptc_pack, ptc_unpack and packed_timestamp_codec_core.
`default_nettype none

package ptc_pkg;

   localparam int SlotBits  = 6;
   localparam int NumSlots  = 10;
   localparam int StampBits = SlotBits * NumSlots;

   // transaction kind
   localparam logic MODE_PACK   = 1'b0;
   localparam logic MODE_UNPACK = 1'b1;

   // response status
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_BAD_ARG = 1'b1;

   localparam logic [7:0] YearBase  = 8'd100;
   localparam logic [7:0] YearLast  = 8'd199;
   localparam logic [9:0] MillisMax = 10'd999;

   // pack path, after range check and digit split
   typedef struct packed {
      logic       bad;
      logic [3:0] y_tens;
      logic [3:0] y_ones;
      logic [3:0] month;      // 1..12
      logic [1:0] d_tens;
      logic [3:0] d_ones;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [3:0] ms_hi;
      logic [5:0] ms_lo;
   } pack_mid_type;

   // unpack path, after per-slot clamping
   typedef struct packed {
      logic [3:0] y_tens;
      logic [3:0] y_ones;
      logic [3:0] month_idx;  // 0..11
      logic [1:0] d_tens;
      logic [3:0] d_ones;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [5:0] ms_hi;
      logic [5:0] ms_lo;
   } unpack_mid_type;

   // quotient by ten for values below 100: multiply by 205, drop 11 bits
   function automatic logic [3:0] div10(input logic [6:0] v);
      logic [14:0] p;
      p = 15'(v) * 15'd205;
      return p[14:11];
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ptc_pack.sv
// Pack path stage: range check and decimal digit split, registered.
// Depends on ptc_pkg.
`default_nettype none

module ptc_pack
   import ptc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic [7:0]   year_since_1900,
   input  wire logic [3:0]   month_index,
   input  wire logic [4:0]   day,
   input  wire logic [4:0]   hour,
   input  wire logic [5:0]   minute,
   input  wire logic [5:0]   second,
   input  wire logic [9:0]   millis,
   output pack_mid_type      mid_ff
);

   pack_mid_type mid_in;
   logic [6:0]   year_off;
   logic [3:0]   y_tens;
   logic [3:0]   d_tens;

   always_comb begin
      year_off = 7'(year_since_1900 - YearBase);
      y_tens   = div10(year_off);
      d_tens   = div10(7'(day));

      mid_in.bad    = (year_since_1900 < YearBase) || (year_since_1900 > YearLast)
                    || (month_index >= 4'd12) || (day == 5'd0) || (hour >= 5'd24)
                    || (minute >= 6'd60) || (second >= 6'd60) || (millis > MillisMax);
      mid_in.y_tens = y_tens;
      mid_in.y_ones = 4'(year_off - 7'(y_tens) * 7'd10);
      mid_in.month  = month_index + 4'd1;
      mid_in.d_tens = d_tens[1:0];
      mid_in.d_ones = 4'(day - 5'(d_tens) * 5'd10);
      mid_in.hour   = hour;
      mid_in.minute = minute;
      mid_in.second = second;
      mid_in.ms_hi  = millis[9:6];
      mid_in.ms_lo  = millis[5:0];
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/ptc_unpack.sv
// Unpack path stage: split the stamp into slots and clamp each, registered.
// Depends on ptc_pkg.
`default_nettype none

module ptc_unpack
   import ptc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic [StampBits-1:0] stamp,
   output unpack_mid_type            mid_ff
);

   unpack_mid_type mid_in;
   logic [SlotBits-1:0] slot [NumSlots];

   always_comb begin
      for (int i = 0; i < NumSlots; i++) begin
         slot[i] = stamp[i*SlotBits +: SlotBits];
      end

      mid_in.y_tens = (slot[9] > 6'd9) ? 4'd9 : slot[9][3:0];
      mid_in.y_ones = (slot[8] > 6'd9) ? 4'd9 : slot[8][3:0];
      if (slot[7] == 6'd0) begin
         mid_in.month_idx = 4'd0;
      end else if (slot[7] > 6'd12) begin
         mid_in.month_idx = 4'd11;
      end else begin
         mid_in.month_idx = 4'(slot[7] - 6'd1);
      end
      mid_in.d_tens = (slot[6] > 6'd3) ? 2'd3 : slot[6][1:0];
      mid_in.d_ones = (slot[5] > 6'd9) ? 4'd9 : slot[5][3:0];
      mid_in.hour   = (slot[4] > 6'd23) ? 5'd23 : slot[4][4:0];
      mid_in.minute = (slot[3] > 6'd59) ? 6'd59 : slot[3];
      mid_in.second = (slot[2] > 6'd59) ? 6'd59 : slot[2];
      mid_in.ms_hi  = slot[1];
      mid_in.ms_lo  = slot[0];
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/packed_timestamp_codec_core.sv
// Top level of the packed timestamp codec: input register, pack/unpack
// stages and output assembly. Depends on ptc_pkg, ptc_pack, ptc_unpack.
`default_nettype none

// Converts calendar fields to a 60-bit stamp of ten 6-bit slots (req_type 0)
// or a stamp back to clamped calendar fields (req_type 1). One transaction
// is taken per clock cycle while busy is low; busy is high during reset and
// in the first cycle after it, and low from then on.
// Each response appears on the rsp_ ports with rsp_valid for exactly one
// cycle, after the three register stages (input capture, range check or
// slot clamp, output assembly). The receiver cannot stall: every response
// must be taken in the cycle it is shown.
module packed_timestamp_codec_core
   import ptc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 start,
   output      logic                 busy,
   input  wire logic                 req_type,
   input  wire logic [StampBits-1:0] req_in_stamp,
   input  wire logic [7:0]           req_in_year_since_1900,
   input  wire logic [3:0]           req_in_month_index,
   input  wire logic [4:0]           req_in_day,
   input  wire logic [4:0]           req_in_hour,
   input  wire logic [5:0]           req_in_minute,
   input  wire logic [5:0]           req_in_second,
   input  wire logic [9:0]           req_in_millis,

   output      logic                 rsp_valid,
   output      logic                 rsp_status,
   output      logic [StampBits-1:0] rsp_out_stamp,
   output      logic [7:0]           rsp_out_year_since_1900,
   output      logic [3:0]           rsp_out_month_index,
   output      logic [4:0]           rsp_out_day,
   output      logic [4:0]           rsp_out_hour,
   output      logic [5:0]           rsp_out_minute,
   output      logic [5:0]           rsp_out_second,
   output      logic [9:0]           rsp_out_millis
);

   logic                 busy_ff;
   logic                 accept;

   // stage 1: captured transaction
   logic                 s1_valid_ff;
   logic                 s1_mode_ff;
   logic [StampBits-1:0] s1_stamp_ff;
   logic [7:0]           s1_year_ff;
   logic [3:0]           s1_month_ff;
   logic [4:0]           s1_day_ff;
   logic [4:0]           s1_hour_ff;
   logic [5:0]           s1_minute_ff;
   logic [5:0]           s1_second_ff;
   logic [9:0]           s1_millis_ff;

   // stage 2: per-path intermediate results
   logic                 s2_valid_ff;
   logic                 s2_mode_ff;
   pack_mid_type         pk_ff;
   unpack_mid_type       up_ff;

   // stage 3: output registers
   logic                 out_valid_ff;
   logic                 out_status_ff,  out_status_in;
   logic [StampBits-1:0] out_stamp_ff,   out_stamp_in;
   logic [7:0]           out_year_ff,    out_year_in;
   logic [3:0]           out_month_ff,   out_month_in;
   logic [4:0]           out_day_ff,     out_day_in;
   logic [4:0]           out_hour_ff,    out_hour_in;
   logic [5:0]           out_minute_ff,  out_minute_in;
   logic [5:0]           out_second_ff,  out_second_in;
   logic [9:0]           out_millis_ff,  out_millis_in;

   logic [5:0]           day_sum;
   logic [11:0]          ms_sum;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff   <= req_type;
      s1_stamp_ff  <= req_in_stamp;
      s1_year_ff   <= req_in_year_since_1900;
      s1_month_ff  <= req_in_month_index;
      s1_day_ff    <= req_in_day;
      s1_hour_ff   <= req_in_hour;
      s1_minute_ff <= req_in_minute;
      s1_second_ff <= req_in_second;
      s1_millis_ff <= req_in_millis;
      s2_mode_ff   <= s1_mode_ff;
   end

   ptc_pack u_pack (
      .clock           (clock),
      .year_since_1900 (s1_year_ff),
      .month_index     (s1_month_ff),
      .day             (s1_day_ff),
      .hour            (s1_hour_ff),
      .minute          (s1_minute_ff),
      .second          (s1_second_ff),
      .millis          (s1_millis_ff),
      .mid_ff          (pk_ff)
   );

   ptc_unpack u_unpack (
      .clock  (clock),
      .stamp  (s1_stamp_ff),
      .mid_ff (up_ff)
   );

   always_comb begin
      out_status_in = STATUS_OK;
      out_stamp_in  = '0;
      out_year_in   = '0;
      out_month_in  = '0;
      out_day_in    = '0;
      out_hour_in   = '0;
      out_minute_in = '0;
      out_second_in = '0;
      out_millis_in = '0;

      day_sum = 6'(up_ff.d_tens) * 6'd10 + 6'(up_ff.d_ones);
      ms_sum  = {up_ff.ms_hi, up_ff.ms_lo};

      if (s2_mode_ff == MODE_PACK) begin
         if (pk_ff.bad) begin
            out_status_in = STATUS_BAD_ARG;
         end else begin
            out_stamp_in = {6'(pk_ff.y_tens), 6'(pk_ff.y_ones), 6'(pk_ff.month),
                            6'(pk_ff.d_tens), 6'(pk_ff.d_ones), 6'(pk_ff.hour),
                            pk_ff.minute, pk_ff.second, 6'(pk_ff.ms_hi), pk_ff.ms_lo};
         end
      end else begin
         out_year_in   = YearBase + 8'(up_ff.y_tens) * 8'd10 + 8'(up_ff.y_ones);
         out_month_in  = up_ff.month_idx;
         if (day_sum == 6'd0) begin
            out_day_in = 5'd1;
         end else if (day_sum > 6'd31) begin
            out_day_in = 5'd31;
         end else begin
            out_day_in = day_sum[4:0];
         end
         out_hour_in   = up_ff.hour;
         out_minute_in = up_ff.minute;
         out_second_in = up_ff.second;
         out_millis_in = (ms_sum > 12'(MillisMax)) ? MillisMax : ms_sum[9:0];
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_stamp_ff  <= out_stamp_in;
      out_year_ff   <= out_year_in;
      out_month_ff  <= out_month_in;
      out_day_ff    <= out_day_in;
      out_hour_ff   <= out_hour_in;
      out_minute_ff <= out_minute_in;
      out_second_ff <= out_second_in;
      out_millis_ff <= out_millis_in;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_status              = out_status_ff;
   assign rsp_out_stamp           = out_stamp_ff;
   assign rsp_out_year_since_1900 = out_year_ff;
   assign rsp_out_month_index     = out_month_ff;
   assign rsp_out_day             = out_day_ff;
   assign rsp_out_hour            = out_hour_ff;
   assign rsp_out_minute          = out_minute_ff;
   assign rsp_out_second          = out_second_ff;
   assign rsp_out_millis          = out_millis_ff;

   // every response traces back to an accepted transaction
   a_rsp_has_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("response without a matching transaction");

   // a rejected pack yields a zero stamp and no calendar fields
   a_bad_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_BAD_ARG) |->
         (rsp_out_stamp == '0 && rsp_out_year_since_1900 == 8'd0))
      else $error("bad-argument response carries data");

   // unpack results never come with a stamp or an error
   a_unpack_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_year_since_1900 != 8'd0) |->
         (rsp_status == STATUS_OK && rsp_out_stamp == '0 && rsp_out_day != 5'd0))
      else $error("unpack response mixes pack fields");

endmodule

`default_nettype wire
